// ----- sv/ffca_pkg.sv -----
package ffca_pkg;

  localparam int MAX_CELLS_DEF = 64;
  localparam int CMD_W         = 2;
  localparam int LEN_W         = 3;
  localparam int ID_W          = 8;
  localparam int START_W       = 6;
  localparam int ACT_W         = 7;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(64);
  localparam logic [ID_W-1:0]  ID_FIRST  = ID_W'(1);

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_ALLOC_NONE,
    OP_FREE,
    OP_COMPACT,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [LEN_W-1:0]    len;
    logic [ID_W-1:0]     rel_id;
    logic [ID_W-1:0]     gid;
  } q_entry_t;

endpackage

// ----- sv/ffca_in_if.sv -----
interface ffca_in_if;
  import ffca_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [LEN_W-1:0] request_length;
  logic [ID_W-1:0]  release_id;

  modport source (output valid, output command, output request_length,
                  output release_id, input ready);
  modport sink   (input valid, input command, input request_length,
                  input release_id, output ready);
endinterface

// ----- sv/ffca_out_if.sv -----
interface ffca_out_if;
  import ffca_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [START_W-1:0] start_cell;
  logic [ID_W-1:0]    given_id;

  modport source (output valid, output status, output start_cell,
                  output given_id, input ready);
  modport sink   (input valid, input status, input start_cell,
                  input given_id, output ready);
endinterface

// ----- sv/ffca_ram.sv -----
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/ffca_fifo.sv -----
module ffca_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ffca_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output ffca_pkg::q_entry_t pop_data,
  output logic              empty
);
  import ffca_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue pushed while full");
`endif
endmodule

// ----- sv/ffca_front.sv -----
module ffca_front (
  input  logic               clk,
  input  logic               rst_n,
  ffca_in_if.sink            in_ch,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output ffca_pkg::q_entry_t q_data
);
  import ffca_pkg::*;

  logic [ID_W-1:0] next_id_r, next_id_nxt;

  assign in_ch.ready = !q_full && !clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

  // classify the word and tag allocates with their id
  always_comb begin
    q_data.len    = in_ch.request_length;
    q_data.rel_id = in_ch.release_id;
    q_data.gid    = '0;
    q_data.op     = OP_NOP;
    unique case (in_ch.command)
      CMD_ALLOC: begin
        q_data.op  = (in_ch.request_length == '0) ? OP_ALLOC_NONE : OP_ALLOC;
        q_data.gid = next_id_r;
      end
      CMD_FREE:    q_data.op = OP_FREE;
      CMD_COMPACT: q_data.op = OP_COMPACT;
      default:     q_data.op = OP_NOP;
    endcase
  end

  // id skips the free code on wrap
  always_comb begin
    next_id_nxt = next_id_r;
    if (q_push && (in_ch.command == CMD_ALLOC)) begin
      next_id_nxt = (next_id_r == '1) ? ID_FIRST : next_id_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= ID_FIRST;
    end else begin
      next_id_r <= next_id_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0)
    else $error("id counter holds the free code");
`endif
endmodule

// ----- sv/ffca_back.sv -----
module ffca_back #(
  parameter int MAX_CELLS = ffca_pkg::MAX_CELLS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [ffca_pkg::ACT_W-1:0] cfg_data,
  input  logic                     q_empty,
  input  ffca_pkg::q_entry_t       q_data,
  output logic                     q_pop,
  output logic                     clearing,
  ffca_out_if.source               out_ch
);
  import ffca_pkg::*;

  localparam int IDX_W = $clog2(MAX_CELLS);
  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SCAN, S_FILL, S_TAIL, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [ACT_W-1:0]   active_r, active_nxt;
  op_t                op_r, op_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [ID_W-1:0]    rel_r, rel_nxt;
  logic [ID_W-1:0]    gid_r, gid_nxt;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [LEN_W-1:0]   run_r, run_nxt;
  logic [LEN_W-1:0]   fill_left_r, fill_left_nxt;
  logic               res_status_r, res_status_nxt;
  logic [START_W-1:0] res_start_r, res_start_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [START_W-1:0] out_start_r, out_start_nxt;
  logic [ID_W-1:0]    out_gid_r, out_gid_nxt;

  logic [CNT_W-1:0]   n_cells;
  logic [IDX_W-1:0]   at_idx;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ID_W-1:0]    ram_wdata;
  logic [ID_W-1:0]    rd_data;

  ffca_ram #(.WIDTH(ID_W), .DEPTH(MAX_CELLS)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // clamp the active size to 1..MAX_CELLS
  always_comb begin
    if (active_r == '0) begin
      n_cells = CNT_W'(1);
    end else if (int'(active_r) > MAX_CELLS) begin
      n_cells = CNT_W'(MAX_CELLS);
    end else begin
      n_cells = CNT_W'(active_r);
    end
  end

  assign at_idx   = pend_idx_r + IDX_W'(1) - IDX_W'(len_r);
  assign clearing = (state_r == S_CLR);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.start_cell = out_start_r;
  assign out_ch.given_id   = out_gid_r;

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = cfg_we ? cfg_data : active_r;
    op_nxt         = op_r;
    len_nxt        = len_r;
    rel_nxt        = rel_r;
    gid_nxt        = gid_r;
    rd_cnt_nxt     = rd_cnt_r;
    wr_ptr_nxt     = wr_ptr_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    run_nxt        = run_r;
    fill_left_nxt  = fill_left_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_gid_nxt    = out_gid_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = wr_ptr_r[IDX_W-1:0];
    ram_wdata      = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        ram_we     = 1'b1;
        wr_ptr_nxt = wr_ptr_r + 1'b1;
        if (wr_ptr_r == CNT_W'(MAX_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          op_nxt         = q_data.op;
          len_nxt        = q_data.len;
          rel_nxt        = q_data.rel_id;
          gid_nxt        = q_data.gid;
          rd_cnt_nxt     = '0;
          wr_ptr_nxt     = '0;
          run_nxt        = '0;
          res_status_nxt = 1'b0;
          res_start_nxt  = '0;
          case (q_data.op)
            OP_ALLOC_NONE: begin
              res_status_nxt = 1'b1;
              state_nxt      = S_DONE;
            end
            OP_NOP:  state_nxt = S_DONE;
            default: state_nxt = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        // reads run one cell ahead of the checks
        if (rd_cnt_r < n_cells) begin
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_cnt_r[IDX_W-1:0];
        end
        if (pend_r) begin
          case (op_r)
            OP_ALLOC: begin
              if (rd_data == '0) begin
                if (({1'b0, run_r} + 4'd1) >= {1'b0, len_r}) begin
                  wr_ptr_nxt    = CNT_W'(at_idx);
                  fill_left_nxt = len_r;
                  res_start_nxt = START_W'(at_idx);
                  pend_nxt      = 1'b0;
                  state_nxt     = S_FILL;
                end else begin
                  run_nxt = run_r + 1'b1;
                end
              end else begin
                run_nxt = '0;
              end
            end
            OP_FREE: begin
              if (rd_data == rel_r) begin
                ram_we    = 1'b1;
                ram_waddr = pend_idx_r;
              end
            end
            OP_COMPACT: begin
              if (rd_data != '0) begin
                ram_we     = 1'b1;
                ram_wdata  = rd_data;
                wr_ptr_nxt = wr_ptr_r + 1'b1;
              end
            end
            default: ;
          endcase
        end else if (rd_cnt_r == n_cells) begin
          case (op_r)
            OP_ALLOC: begin
              res_status_nxt = 1'b1;
              state_nxt      = S_DONE;
            end
            OP_COMPACT: state_nxt = S_TAIL;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        ram_we        = 1'b1;
        ram_wdata     = gid_r;
        wr_ptr_nxt    = wr_ptr_r + 1'b1;
        fill_left_nxt = fill_left_r - 1'b1;
        if (fill_left_r == LEN_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_TAIL: begin
        if (wr_ptr_r < n_cells) begin
          ram_we     = 1'b1;
          wr_ptr_nxt = wr_ptr_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          out_gid_nxt    = gid_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      active_r    <= ACT_RESET;
      wr_ptr_r    <= '0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    len_r        <= len_nxt;
    rel_r        <= rel_nxt;
    gid_r        <= gid_nxt;
    pend_idx_r   <= pend_idx_nxt;
    run_r        <= run_nxt;
    fill_left_r  <= fill_left_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_gid_r    <= out_gid_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !q_pop)
    else $error("command taken during clearing pass");
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (wr_ptr_r < n_cells))
    else $error("fill beyond active cells");
  a_run_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && op_r == OP_ALLOC) |-> (run_r < len_r))
    else $error("free run passed request length");
`endif
endmodule

// ----- sv/first_fit_cell_allocator.sv -----
// channel  dir  handshake          payload
// in_ch    in   valid/ready        command, request_length, release_id
// out_ch   out  valid/ready        status, start_cell, given_id
// cfg_*    in   cfg_we, no ready   cfg_data = active_cells
//
// each command leaves the queue, is scanned, then loads out_ch; free and a refused allocate
// scan all n active cells, compact then clears each freed tail cell, and a placed allocate
// scans up to its fit and then fills len cells; zero length and the unused code skip
// the scan; n is the active cell count, one memory read and write per cycle
// after reset a clearing pass zeroes all MAX_CELLS cells of the memory; in_ch.ready stays low
// a two-word queue lets the front take words while the back is busy or out_ch stalls
module first_fit_cell_allocator #(
  parameter int MAX_CELLS = ffca_pkg::MAX_CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ffca_pkg::ACT_W-1:0] cfg_data,
  ffca_in_if.sink                    in_ch,
  ffca_out_if.source                 out_ch
);
  import ffca_pkg::*;

  q_entry_t push_data;
  q_entry_t pop_data;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  logic     clearing;

  ffca_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  ffca_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  ffca_back #(.MAX_CELLS(MAX_CELLS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import ffca_pkg::*;

  localparam int               CELLS        = MAX_CELLS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int               SETTLE_WAIT  = 3 * CELLS + 16;
  localparam int               RANDOM_WORDS = 1700;
  localparam int               NUM_PHASES   = 13;

  typedef struct packed {
    logic               status;
    logic [START_W-1:0] start_cell;
    logic [ID_W-1:0]    given_id;
  } alloc_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_data;

  ffca_in_if  in_ch ();
  ffca_out_if out_ch ();

  first_fit_cell_allocator #(
    .MAX_CELLS(CELLS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // allocator shadow state
  logic [ID_W-1:0]  owner_of [CELLS];
  logic [ID_W-1:0]  id_counter;
  logic [ACT_W-1:0] active_reg;
  alloc_result_t    pending_results [$];
  logic [ID_W-1:0]  live_ids [$];

  bit no_idle;
  int mismatches;
  int words_sent;
  int results_checked;
  int alloc_placed;
  int alloc_refused;
  int id_wraps;

  function automatic alloc_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [LEN_W-1:0] len,
                                                  logic [ID_W-1:0]  rel);
    alloc_result_t r;
    int            n;
    int            run;
    int            at;
    int            w;
    bit            found;
    r     = '0;
    n     = (active_reg == '0) ? 1 : (active_reg > CELLS) ? CELLS : int'(active_reg);
    run   = 0;
    at    = 0;
    w     = 0;
    found = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        r.given_id = id_counter;
        if (len != '0) begin
          for (int i = 0; i < n; i++) begin
            if (owner_of[i] == '0) begin
              run++;
              if (run >= int'(len)) begin
                at    = i + 1 - int'(len);
                found = 1'b1;
                break;
              end
            end else begin
              run = 0;
            end
          end
        end
        if (found) begin
          for (int i = at; i < at + int'(len); i++) owner_of[i] = id_counter;
          r.start_cell = START_W'(at);
          live_ids.push_back(id_counter);
          alloc_placed++;
        end else begin
          r.status = 1'b1;
          alloc_refused++;
        end
        // id is spent either way, and zero is the free code
        id_counter++;
        if (id_counter == '0) begin
          id_counter = ID_FIRST;
          id_wraps++;
        end
      end
      CMD_FREE: begin
        for (int i = 0; i < n; i++)
          if (owner_of[i] == rel) owner_of[i] = '0;
      end
      CMD_COMPACT: begin
        for (int i = 0; i < n; i++) begin
          if (owner_of[i] != '0) begin
            owner_of[w] = owner_of[i];
            w++;
          end
        end
        for (int i = w; i < n; i++) owner_of[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                           logic [ID_W-1:0] rel);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.request_length <= len;
    in_ch.release_id     <= rel;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_command(cmd, len, rel));
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_active(logic [ACT_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_data   <= value;
    active_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void compare_field(string name, logic [ID_W-1:0] want,
                                        logic [ID_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result word with no command waiting: status %0d start %0d id %0d",
               out_ch.status, out_ch.start_cell, out_ch.given_id);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", ID_W'(want.status), ID_W'(out_ch.status));
        compare_field("start_cell", ID_W'(want.start_cell), ID_W'(out_ch.start_cell));
        compare_field("given_id", want.given_id, out_ch.given_id);
        results_checked++;
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic test_basic_commands();
    send_word(CMD_ALLOC, 3'd1, '0);          // lands at cell 0
    send_word(CMD_ALLOC, 3'd7, '0);
    send_word(CMD_ALLOC, 3'd0, '1);          // zero length: refused, id still spent
    send_word(CMD_ALLOC, 3'd2, '0);
    send_word(CMD_FREE, '0, owner_of[1]);    // opens a hole of seven
    send_word(CMD_ALLOC, 3'd3, '0);          // first fit goes into the hole
    send_word(CMD_ALLOC, 3'd7, '0);          // hole remainder too short
    send_word(CMD_FREE, '1, '0);             // id zero changes nothing
    send_word(CMD_FREE, '0, '1);             // id never handed out
    send_word(CMD_UNUSED, '1, '1);
    send_word(CMD_COMPACT, '0, '0);
    send_word(CMD_ALLOC, 3'd7, '0);
  endtask

  task automatic test_size_extremes();
    write_active(7'd1);
    send_word(CMD_ALLOC, 3'd1, '0);
    send_word(CMD_FREE, '0, owner_of[0]);
    send_word(CMD_ALLOC, 3'd1, '0);
    send_word(CMD_ALLOC, 3'd2, '0);          // longer than the active row
    write_active('0);                        // behaves as one cell
    send_word(CMD_ALLOC, 3'd1, '0);
    send_word(CMD_COMPACT, '0, '0);          // cells past the row stay put
    write_active('1);                        // clamps to the built size
    send_word(CMD_ALLOC, 3'd7, '1);
    send_word(CMD_COMPACT, '1, '1);
    write_active(7'd65);
    send_word(CMD_ALLOC, 3'd7, '0);
  endtask

  task automatic random_word();
    int              pick;
    int              slot;
    logic [ID_W-1:0] rel;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_word(CMD_ALLOC, LEN_W'($urandom_range(1, 7)), ID_W'($urandom()));
    end else if (pick < 78 && live_ids.size() > 0) begin
      slot = $urandom_range(live_ids.size() - 1);
      rel  = live_ids[slot];
      live_ids.delete(slot);
      send_word(CMD_FREE, LEN_W'($urandom()), rel);
    end else if (pick < 86) begin
      send_word(CMD_COMPACT, LEN_W'($urandom()), ID_W'($urandom()));
    end else if (pick < 90) begin
      send_word(CMD_ALLOC, '0, ID_W'($urandom()));
    end else if (pick < 94) begin
      send_word(CMD_UNUSED, LEN_W'($urandom()), ID_W'($urandom()));
    end else begin
      send_word(CMD_FREE, LEN_W'($urandom()), ID_W'($urandom()));
    end
  endtask

  task automatic test_random_traffic();
    logic [ACT_W-1:0] sizes [NUM_PHASES] = '{7'd64, 7'd8, 7'd2, 7'd64, 7'd127, 7'd33,
                                             7'd0, 7'd64, 7'd16, 7'd65, 7'd1, 7'd48,
                                             7'd64};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(sizes[p]);
      for (int k = 0; k < RANDOM_WORDS / NUM_PHASES; k++) begin
        if (k % 40 == 0) no_idle = ($urandom_range(3) == 0);
        // now and then let everything drain before going on
        if ($urandom_range(49) == 0) drain();
        random_word();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_data             = ACT_RESET;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_ALLOC;
    in_ch.request_length = '0;
    in_ch.release_id     = '0;
    no_idle              = 1'b0;
    mismatches           = 0;
    words_sent           = 0;
    results_checked      = 0;
    alloc_placed         = 0;
    alloc_refused        = 0;
    id_wraps             = 0;
    for (int i = 0; i < CELLS; i++) owner_of[i] = '0;
    id_counter = ID_FIRST;
    active_reg = ACT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_size_extremes();
    test_random_traffic();

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("%0d command words sent, %0d results checked, %0d placed, %0d refused",
             words_sent, results_checked, alloc_placed, alloc_refused);
    $display("id counter wrapped %0d times; active sizes from 0 to 127 exercised",
             id_wraps);
    if (mismatches == 0) begin
      $display("first_fit_cell_allocator regression: pass");
    end else begin
      $display("first_fit_cell_allocator regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("first_fit_cell_allocator regression: fail");
    $finish;
  end

endmodule
